/* design/dqdr_pkg.sv */
// dqdr_pkg: shared widths, operation and status codes, and the control
// structs that pass between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqdr_pkg;

   localparam int DATA_W          = 32;
   localparam int FUNC_W          = 3;
   localparam int STATUS_W        = 2;
   localparam int STORE_DEPTH_DEF = 64;

   // operation codes carried in the request
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_READ_OUT   = 3'd2,
      FUNC_COUNT_DUPS = 3'd3,
      FUNC_DROP_DUPS  = 3'd4
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // source of a single closing result
   typedef enum logic [1:0] {
      REP_OK    = 2'd0,
      REP_FULL  = 2'd1,
      REP_EMPTY = 2'd2,
      REP_TOTAL = 2'd3
   } reply_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          take_req;
      logic          push;
      logic          clear_outer;
      logic          rd_entry;
      logic          load_v;
      logic          scan;
      logic          step;
      logic          emit_entry;
      logic          reply;
      reply_sel_type reply_sel;
   } dqdr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              empty;
      logic              out_free;
      logic              outer_last;
      logic              scan_done;
   } dqdr_stat_type;

endpackage

`default_nettype wire

/* design/dqdr_channels_if.sv */
// dqdr channel interfaces: request channel and result channel, each with
// valid/ready handshake and payload. Depends on dqdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dqdr_req_if;
   import dqdr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, func, value, input ready);
   modport sink   (input valid, func, value, output ready);
endinterface

interface dqdr_rsp_if;
   import dqdr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic [STATUS_W-1:0]      status;
   logic                     last;

   modport source (output valid, data, status, last, input ready);
   modport sink   (input valid, data, status, last, output ready);
endinterface

`default_nettype wire

/* design/deque_with_duplicate_removal_core.sv */
// Bounded double-ended store of signed values with duplicate count and removal.
// Requests arrive on req_chan (func, value); results leave on rsp_chan
// (data, status, last). Both channels use valid/ready; a request or result
// moves on a clock edge with valid and ready high.
// One request is handled at a time; req_chan.ready is high while idle, even
// if the previous result still waits in the output register.
// Results, n = entries held:
//   push, unused code, empty-store cases: a single result
//   read out: n results, one per entry in order from the front,
//     last flagged on the back entry
//   count duplicates: each entry scanned against the whole store, one result
//   remove duplicates: each entry scanned against later entries, scans end on a match
// The duplicate passes use the single read port of the entry memory; in a scan
// one entry is read and compared per cycle.
// Reset (synchronous, active high) empties the store; memory contents are
// not cleared and no clearing pass is needed.
// A stalled receiver holds the result register; read out and the closing
// result simply wait until the register is taken.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_duplicate_removal_core #(
   parameter int STORE_DEPTH = dqdr_pkg::STORE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dqdr_req_if.sink    req_chan,
   dqdr_rsp_if.source  rsp_chan
);
   import dqdr_pkg::*;

   dqdr_cmd_type  cmd;
   dqdr_stat_type stat;

   // operation sequencer
   dqdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, counters and result register
   dqdr_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_func   (req_chan.func),
      .req_value  (req_chan.value),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_data   (rsp_chan.data),
      .rsp_status (rsp_chan.status),
      .rsp_last   (rsp_chan.last),
      .cmd        (cmd),
      .stat       (stat)
   );

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.reply || cmd.emit_entry) |-> stat.out_free)
      else $error("result register loaded while a result still waits");

   // a loaded result shows on the channel next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (cmd.reply || cmd.emit_entry) |=> rsp_chan.valid)
      else $error("loaded result not presented");

   // only one request in flight
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   // pushes never overrun the store
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push into a full store");

endmodule

`default_nettype wire

/* design/dqdr_datapath.sv */
// dqdr_datapath: entry memory, ring pointers, scan counters, duplicate
// compare and the result register. Driven by dqdr_ctrl; depends on dqdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqdr_datapath #(
   parameter int STORE_DEPTH = dqdr_pkg::STORE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dqdr_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [dqdr_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dqdr_pkg::DATA_W-1:0] rsp_data,
   output logic [dqdr_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_last,
   input  dqdr_pkg::dqdr_cmd_type             cmd,
   output dqdr_pkg::dqdr_stat_type            stat
);
   import dqdr_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(STORE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STORE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

   // ring position of an offset from the front
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [DATA_W-1:0]   entry_mem [STORE_DEPTH];
   logic [DATA_W-1:0]   rdata_ff;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic [CNT_W-1:0]    pj_ff, pj_in;
   logic [CNT_W-1:0]    wr_ff, wr_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [DATA_W-1:0]   v_ff, v_in;
   logic                hit_ff, hit_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                out_vld_ff, out_vld_in;
   logic [DATA_W-1:0]   out_data_ff, out_data_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [DATA_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;

   logic                dropping;
   logic                outer_last;
   logic                out_free;

   assign dropping   = (func_ff == FUNC_DROP_DUPS);
   assign outer_last = ((CNT_W + 1)'(i_ff) + 1'b1) == (CNT_W + 1)'(count_ff);
   assign out_free   = ~out_vld_ff | rsp_ready;

   // next state of the datapath registers and memory port controls
   always_comb begin
      func_in       = func_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pj_in         = pj_ff;
      wr_in         = wr_ff;
      total_in      = total_ff;
      v_in          = v_ff;
      hit_in        = hit_ff;
      rd_vld_in     = rd_vld_ff;
      out_vld_in    = out_vld_ff & ~rsp_ready;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = ring_pos(front_ff, wr_ff);
      mem_wdata     = v_ff;
      mem_re        = 1'b0;
      mem_raddr     = ring_pos(front_ff, i_ff);

      // capture the request
      if (cmd.take_req) begin
         func_in  = req_func;
         value_in = req_value;
      end

      // push at either end
      if (cmd.push) begin
         mem_we    = 1'b1;
         mem_wdata = value_ff;
         if (func_ff == FUNC_PUSH_FRONT) begin
            front_in  = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
            mem_waddr = front_in;
         end else begin
            mem_waddr = ring_pos(front_ff, count_ff);
         end
         count_in = count_ff + 1'b1;
      end

      // start of an outer pass
      if (cmd.clear_outer) begin
         i_in     = '0;
         wr_in    = '0;
         total_in = '0;
      end

      // read the entry at the outer index
      if (cmd.rd_entry) begin
         mem_re    = 1'b1;
         mem_raddr = ring_pos(front_ff, i_ff);
      end

      // hold the outer value and set up the inner scan
      if (cmd.load_v) begin
         v_in      = rdata_ff;
         hit_in    = 1'b0;
         rd_vld_in = 1'b0;
         j_in      = dropping ? i_ff + 1'b1 : '0;
      end

      // inner scan: one read issued and one compare per cycle
      if (cmd.scan) begin
         rd_vld_in = 1'b0;
         if (j_ff < count_ff) begin
            mem_re    = 1'b1;
            mem_raddr = ring_pos(front_ff, j_ff);
            pj_in     = j_ff;
            j_in      = j_ff + 1'b1;
            rd_vld_in = 1'b1;
         end
         if (rd_vld_ff && (rdata_ff == v_ff) && (dropping || (pj_ff != i_ff))) begin
            hit_in = 1'b1;
         end
      end

      // close one outer entry
      if (cmd.step) begin
         i_in = i_ff + 1'b1;
         if (dropping) begin
            if (!hit_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ring_pos(front_ff, wr_ff);
               mem_wdata = v_ff;
               wr_in     = wr_ff + 1'b1;
            end
            if (outer_last) begin
               count_in = wr_in;
            end
         end else begin
            total_in = total_ff + CNT_W'(hit_ff);
         end
      end

      // one read-out result
      if (cmd.emit_entry) begin
         out_vld_in    = 1'b1;
         out_data_in   = rdata_ff;
         out_status_in = ST_OK;
         out_last_in   = outer_last;
         i_in          = i_ff + 1'b1;
      end

      // closing single result
      if (cmd.reply) begin
         out_vld_in  = 1'b1;
         out_last_in = 1'b1;
         case (cmd.reply_sel)
            REP_FULL: begin
               out_data_in   = '0;
               out_status_in = ST_FULL;
            end
            REP_EMPTY: begin
               out_data_in   = '0;
               out_status_in = ST_EMPTY;
            end
            REP_TOTAL: begin
               out_data_in   = {{(DATA_W - CNT_W){1'b0}}, total_ff};
               out_status_in = ST_OK;
            end
            default: begin
               out_data_in   = '0;
               out_status_in = ST_OK;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         wr_ff      <= '0;
         total_ff   <= '0;
         hit_ff     <= 1'b0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         wr_ff      <= wr_in;
         total_ff   <= total_in;
         hit_ff     <= hit_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      pj_ff         <= pj_in;
      v_ff          <= v_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= entry_mem[mem_raddr];
      end
   end

   // status towards the controller
   always_comb begin
      stat.func       = func_ff;
      stat.full       = (count_ff == DEPTH_C);
      stat.empty      = (count_ff == '0);
      stat.out_free   = out_free;
      stat.outer_last = outer_last;
      stat.scan_done  = ((j_ff >= count_ff) && !rd_vld_ff) || (dropping && hit_ff);
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

/* design/dqdr_ctrl.sv */
// dqdr_ctrl: operation sequencer. Accepts a request, walks the datapath
// through the push, read-out or duplicate passes. Depends on dqdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqdr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dqdr_pkg::dqdr_stat_type stat,
   output dqdr_pkg::dqdr_cmd_type  cmd
);
   import dqdr_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_DISPATCH   = 9'b000000010,
      S_RD_ISSUE   = 9'b000000100,
      S_RD_EMIT    = 9'b000001000,
      S_LOAD_ISSUE = 9'b000010000,
      S_LOAD_WAIT  = 9'b000100000,
      S_SCAN       = 9'b001000000,
      S_STEP       = 9'b010000000,
      S_REPLY      = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   reply_sel_type reply_sel_ff, reply_sel_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      reply_sel_in  = reply_sel_ff;
      cmd           = '0;
      cmd.reply_sel = reply_sel_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end

         // decode the captured operation
         S_DISPATCH: begin
            unique case (stat.func) inside
               FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                  if (stat.full) begin
                     reply_sel_in = REP_FULL;
                  end else begin
                     cmd.push     = 1'b1;
                     reply_sel_in = REP_OK;
                  end
                  state_in = S_REPLY;
               end
               FUNC_READ_OUT: begin
                  if (stat.empty) begin
                     reply_sel_in = REP_EMPTY;
                     state_in     = S_REPLY;
                  end else begin
                     cmd.clear_outer = 1'b1;
                     state_in        = S_RD_ISSUE;
                  end
               end
               FUNC_COUNT_DUPS, FUNC_DROP_DUPS: begin
                  if (stat.empty) begin
                     reply_sel_in = REP_OK;
                     state_in     = S_REPLY;
                  end else begin
                     reply_sel_in    = (stat.func == FUNC_COUNT_DUPS) ? REP_TOTAL : REP_OK;
                     cmd.clear_outer = 1'b1;
                     state_in        = S_LOAD_ISSUE;
                  end
               end
               default: begin
                  reply_sel_in = REP_OK;
                  state_in     = S_REPLY;
               end
            endcase
         end

         // read-out, one entry per pass
         S_RD_ISSUE: begin
            cmd.rd_entry = 1'b1;
            state_in     = S_RD_EMIT;
         end

         S_RD_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_entry = 1'b1;
               state_in       = stat.outer_last ? S_IDLE : S_RD_ISSUE;
            end
         end

         // duplicate passes: fetch outer entry, scan, close
         S_LOAD_ISSUE: begin
            cmd.rd_entry = 1'b1;
            state_in     = S_LOAD_WAIT;
         end

         S_LOAD_WAIT: begin
            cmd.load_v = 1'b1;
            state_in   = S_SCAN;
         end

         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_STEP;
            end else begin
               cmd.scan = 1'b1;
            end
         end

         S_STEP: begin
            cmd.step = 1'b1;
            state_in = stat.outer_last ? S_REPLY : S_LOAD_ISSUE;
         end

         S_REPLY: begin
            if (stat.out_free) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reply_sel_ff <= REP_OK;
      end else begin
         state_ff     <= state_in;
         reply_sel_ff <= reply_sel_in;
      end
   end

endmodule

`default_nettype wire

/* sim/deque_with_duplicate_removal_core_test.sv */
// Self-checking test of deque_with_duplicate_removal_core: directed and random
// requests, an internal predictor of the ring contents, and in-order result checks.
// Depends on dqdr_pkg, dqdr_channels_if and the core itself.
`timescale 1ns / 1ps

module deque_with_duplicate_removal_core_test;
   import dqdr_pkg::*;

   localparam int DEPTH         = STORE_DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 120;
   localparam int FILL_AT       = 40;
   localparam int QUIET_ITEMS   = 25;
   localparam int PRESSURE_AT   = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 50;
   localparam int POOL_SIZE     = 6;
   localparam int REPORT_CAP    = 30;
   // worst case: every request a full-store scan with every result stalled
   localparam int CYCLE_LIMIT   = 3_000_000;

   // operation codes with no function in the block
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic                     last;
   } rsp_beat_type;

   // ring predictor and in-order result checker
   class dqdr_scoreboard;
      logic signed [DATA_W-1:0] ring [DEPTH];
      int unsigned              front;
      int unsigned              held;
      rsp_beat_type             awaited [$];
      int                       errors;
      int                       checked;
      int                       deepest;
      int                       full_refusals;
      int                       op_seen [8];

      function new();
         front = 0;
         held  = 0;
      endfunction

      function int unsigned slot(int unsigned offset);
         return (front + offset) % DEPTH;
      endfunction

      function void add_beat(logic signed [DATA_W-1:0] data, status_type status,
                             logic last);
         rsp_beat_type beat;
         beat.data   = data;
         beat.status = status;
         beat.last   = last;
         awaited.push_back(beat);
      endfunction

      // work out the results of one accepted request
      function void note_request(logic [FUNC_W-1:0] func,
                                 logic signed [DATA_W-1:0] value);
         int unsigned              i;
         int unsigned              j;
         int unsigned              hits;
         int unsigned              dup_total;
         int unsigned              wr;
         logic                     later;
         logic signed [DATA_W-1:0] v;
         op_seen[func]++;
         case (func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
               if (held >= DEPTH) begin
                  full_refusals++;
                  add_beat('0, ST_FULL, 1'b1);
               end else begin
                  if (func == FUNC_PUSH_FRONT) begin
                     front = (front + DEPTH - 1) % DEPTH;
                     ring[front] = value;
                  end else begin
                     ring[slot(held)] = value;
                  end
                  held++;
                  if (held > deepest) deepest = held;
                  add_beat('0, ST_OK, 1'b1);
               end
            end
            FUNC_READ_OUT: begin
               if (held == 0) begin
                  add_beat('0, ST_EMPTY, 1'b1);
               end else begin
                  for (i = 0; i < held; i++)
                     add_beat(ring[slot(i)], ST_OK, i + 1 == held);
               end
            end
            FUNC_COUNT_DUPS: begin
               // positions whose value turns up more than once
               dup_total = 0;
               for (i = 0; i < held; i++) begin
                  v    = ring[slot(i)];
                  hits = 0;
                  for (j = 0; j < held; j++)
                     if (ring[slot(j)] == v) hits++;
                  if (hits > 1) dup_total++;
               end
               add_beat(dup_total, ST_OK, 1'b1);
            end
            FUNC_DROP_DUPS: begin
               // keep only the last occurrence of each value, in order
               wr = 0;
               for (i = 0; i < held; i++) begin
                  v     = ring[slot(i)];
                  later = 1'b0;
                  for (j = i + 1; j < held; j++)
                     if (ring[slot(j)] == v) later = 1'b1;
                  if (!later) begin
                     ring[slot(wr)] = v;
                     wr++;
                  end
               end
               held = wr;
               add_beat('0, ST_OK, 1'b1);
            end
            default: begin
               add_beat('0, ST_OK, 1'b1);
            end
         endcase
      endfunction

      function void report(string what, longint want, longint got);
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_result(logic signed [DATA_W-1:0] data,
                                 logic [STATUS_W-1:0] status, logic last);
         rsp_beat_type want;
         checked++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: unexpected result, expected none, data %0d status %0d",
                        $time, data, status);
            return;
         end
         want = awaited.pop_front();
         if (data !== want.data) report("data", want.data, data);
         if (status !== want.status) report("status", want.status, status);
         if (last !== want.last) report("last", want.last, last);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic gaps_on;
   logic hold_off_request;
   int   cycle_count;
   int   item_no;

   logic signed [DATA_W-1:0] value_pool [POOL_SIZE];
   dqdr_scoreboard           ledger;

   dqdr_req_if req_chan ();
   dqdr_rsp_if rsp_chan ();

   deque_with_duplicate_removal_core #(
      .STORE_DEPTH (DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // known values on every input from time zero
   initial begin
      reset            = 1'b1;
      gaps_on          = 1'b1;
      hold_off_request = 1'b0;
      item_no          = 0;
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_PUSH_BACK;
      req_chan.value   = '0;
      rsp_chan.ready   = 1'b0;
      ledger           = new();
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // result side: checks, random stalls and the one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            ledger.check_result(rsp_chan.data, rsp_chan.status, rsp_chan.last);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // offer one request, maybe after an idle burst, and wait for it to be taken
   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic signed [DATA_W-1:0] value);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func  <= func;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_request(func, value);
      item_no++;
   endtask

   // mostly values from a small pool so that duplicates are common
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // stimulus
   initial begin
      int   k;
      int   pick;
      int   c;
      logic filled;
      filled = 1'b0;
      for (k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, spare codes, extreme values, each operation
      send_request(FUNC_READ_OUT, '0);
      send_request(FUNC_COUNT_DUPS, '0);
      send_request(FUNC_DROP_DUPS, '0);
      for (c = FUNC_SPARE_FIRST; c <= FUNC_SPARE_LAST; c++)
         send_request(FUNC_W'(c), 32'sh7fffffff);
      send_request(FUNC_PUSH_BACK, 32'sh7fffffff);
      send_request(FUNC_PUSH_FRONT, 32'sh80000000);
      send_request(FUNC_PUSH_BACK, '0);
      send_request(FUNC_PUSH_FRONT, -32'sd1);
      send_request(FUNC_PUSH_BACK, 32'sh7fffffff);
      send_request(FUNC_PUSH_FRONT, -32'sd1);
      send_request(FUNC_PUSH_BACK, 32'sh55555555);
      send_request(FUNC_PUSH_BACK, 32'shaaaaaaaa);
      send_request(FUNC_READ_OUT, '0);
      send_request(FUNC_COUNT_DUPS, '0);
      send_request(FUNC_DROP_DUPS, '0);
      send_request(FUNC_READ_OUT, '0);
      send_request(FUNC_COUNT_DUPS, '0);

      // random mix, with one run up to a full store and beyond
      k = 0;
      while (k < RANDOM_ITEMS) begin
         gaps_on = (k < RANDOM_ITEMS - QUIET_ITEMS);
         if (k == PRESSURE_AT) hold_off_request = 1'b1;
         if (!filled && k >= FILL_AT) begin
            filled = 1'b1;
            while (ledger.held < DEPTH) begin
               send_request($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                            $urandom_range(0, 3) == 0 ? pick_value() : $urandom);
               k++;
            end
            repeat (3) begin
               send_request($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                            pick_value());
               k++;
            end
            send_request(FUNC_READ_OUT, $urandom);
            send_request(FUNC_COUNT_DUPS, $urandom);
            send_request(FUNC_DROP_DUPS, $urandom);
            send_request(FUNC_READ_OUT, $urandom);
            k += 4;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               send_request(FUNC_PUSH_FRONT, pick_value());
            else if (pick < 70)
               send_request(FUNC_PUSH_BACK, pick_value());
            else if (pick < 78)
               send_request(FUNC_READ_OUT, $urandom);
            else if (pick < 86)
               send_request(FUNC_COUNT_DUPS, $urandom);
            else if (pick < 94)
               send_request(FUNC_DROP_DUPS, $urandom);
            else
               send_request(FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                            $urandom);
            k++;
         end
      end
      gaps_on = 1'b0;
      req_chan.valid <= 1'b0;

      // drain, then give any stray result time to show
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.awaited.size() != 0) begin
         ledger.errors++;
         $display("%0t: %0d expected results never arrived", $time, ledger.awaited.size());
      end

      $display("tb: %0d requests: %0d front, %0d back pushes (%0d full), %0d read-outs",
               item_no, ledger.op_seen[FUNC_PUSH_FRONT], ledger.op_seen[FUNC_PUSH_BACK],
               ledger.full_refusals, ledger.op_seen[FUNC_READ_OUT]);
      $display("tb: %0d counts, %0d removals, %0d results checked, store reached %0d of %0d",
               ledger.op_seen[FUNC_COUNT_DUPS], ledger.op_seen[FUNC_DROP_DUPS],
               ledger.checked, ledger.deepest, DEPTH);
      if (ledger.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
